>>> hdl/rss_pkg.sv
`default_nettype none
package rss_pkg;

	localparam int KEY_W        = 32;
	localparam int MAX_KEYS_DEF = 64;

	// per-cycle command shared by every cell of the row
	typedef struct packed {
		logic ins;
		logic shift;
	} rss_ctl_t;

	typedef logic signed [KEY_W-1:0] key_t;

endpackage
`default_nettype wire

>>> hdl/rss_cell.sv
`default_nettype none
module rss_cell (
	input  wire logic              clk,
	input  wire rss_pkg::rss_ctl_t ctl,
	input  wire logic              occ,
	input  wire rss_pkg::key_t     in_key,
	input  wire rss_pkg::key_t     left_key,
	input  wire logic              left_gt,
	input  wire rss_pkg::key_t     right_key,
	output rss_pkg::key_t          cell_key,
	output logic                   gt
);
	import rss_pkg::*;

	key_t key_q;

	assign cell_key = key_q;
	// held key sorts after the new word
	assign gt = occ && (key_q > in_key);

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			key_q <= right_key;
		end else if (ctl.ins) begin
			if (left_gt) begin
				key_q <= left_key;
			end else if (gt || !occ) begin
				key_q <= in_key;
			end
		end
	end

endmodule
`default_nettype wire

>>> hdl/regular_sampling_sorter_unit.sv
// latency: a key is placed in the cell row in the cycle it is accepted, unless the row is full;
// the first sorted word is offered in the cycle after the word marked last
// throughput: one key per cycle while loading, one sorted word per cycle while unloading and
// out_ready is high; no keys are taken while unloading
// reset: asynchronous, clears the key count and the load/unload state; cell contents are
// left undefined and only occupied cells are ever read
`default_nettype none
module regular_sampling_sorter_unit #(
	parameter int MAX_KEYS = rss_pkg::MAX_KEYS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire rss_pkg::key_t key,
	input  wire logic          last,
	output logic               out_valid,
	input  wire logic          out_ready,
	output rss_pkg::key_t      sorted_key,
	output logic               final_res
);
	import rss_pkg::*;

	localparam int CNT_W = $clog2(MAX_KEYS + 1);

	typedef enum logic [1:0] {
		ST_LOAD  = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             in_fire;
	logic             out_fire;
	logic             full;
	rss_ctl_t         ctl;
	logic             occ   [MAX_KEYS];
	key_t             keys  [MAX_KEYS];
	logic             gts   [MAX_KEYS];

	assign in_ready   = (state_q == ST_LOAD);
	assign out_valid  = (state_q == ST_DRAIN);
	assign in_fire    = in_valid && in_ready;
	assign out_fire   = out_valid && out_ready;
	assign full       = (cnt_q == CNT_W'(MAX_KEYS));
	assign ctl        = '{ins: in_fire && !full, shift: out_fire};
	assign sorted_key = keys[0];
	assign final_res  = (cnt_q == CNT_W'(1));

	for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
		assign occ[i] = (cnt_q > CNT_W'(i));
		rss_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.occ      (occ[i]),
			.in_key   (key),
			.left_key (keys[(i == 0) ? 0 : i - 1]),
			.left_gt  ((i == 0) ? 1'b0 : gts[(i == 0) ? 0 : i - 1]),
			.right_key(keys[(i == MAX_KEYS - 1) ? i : i + 1]),
			.cell_key (keys[i]),
			.gt       (gts[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (ctl.ins) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (in_fire && last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (out_fire) begin
						cnt_q <= cnt_q - CNT_W'(1);
						if (final_res) begin
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
					cnt_q   <= '0;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

>>> hdl/rss_checker.sv
`default_nettype none
module rss_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          in_valid,
	input wire logic          in_ready,
	input wire logic          last,
	input wire logic          out_valid,
	input wire logic          out_ready,
	input wire rss_pkg::key_t sorted_key,
	input wire logic          final_res
);
	// one set at a time: no loading while unloading
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while unloading");

	// closing word starts the unload
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && last) |=> out_valid)
		else $error("no output after closing word");

	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && final_res) |=> (!out_valid && in_ready))
		else $error("unload did not finish after final word");

	a_more: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !final_res) |=> out_valid)
		else $error("unload stopped before final word");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(sorted_key) && $stable(final_res)))
		else $error("stalled output word changed");

endmodule

bind regular_sampling_sorter_unit rss_checker u_rss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.last      (last),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.sorted_key(sorted_key),
	.final_res (final_res)
);
`default_nettype wire

>>> sim/tb_regular_sampling_sorter_unit.sv
`default_nettype none
module tb_regular_sampling_sorter_unit;

	import rss_pkg::*;

	localparam int SET_CAP      = MAX_KEYS_DEF;
	localparam int HOLD_CYCLES  = 400;
	localparam int STALL_LIMIT  = 3000;
	localparam int PHASE_WORDS  = 40;
	localparam int TAIL_CYCLES  = 10;

	typedef enum int {
		KEYS_WIDE,
		KEYS_CLUSTERED,
		KEYS_EXTREME
	} key_mix_t;

	typedef struct packed {
		key_t k;
		logic l;
		logic typed;
		key_t k_exp;
	} stim_row_t;

	typedef struct packed {
		key_t k;
		logic fin;
	} sorted_word_t;

	localparam int N_DIR = 20;
	localparam stim_row_t DIR_ROWS [N_DIR] = '{
		// single-key sets straight after reset, result known outright
		'{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
		'{32'h7fff_ffff, 1'b1, 1'b1, 32'h7fff_ffff},
		'{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
		'{32'hffff_ffff, 1'b1, 1'b1, 32'hffff_ffff},
		'{32'h0000_0001, 1'b1, 1'b1, 32'h0000_0001},
		// mixed signs, duplicate, both extremes
		'{32'h0000_0005, 1'b0, 1'b0, 32'h0},
		'{32'hffff_fffd, 1'b0, 1'b0, 32'h0},
		'{32'h0000_0005, 1'b0, 1'b0, 32'h0},
		'{32'h7fff_ffff, 1'b0, 1'b0, 32'h0},
		'{32'h8000_0000, 1'b0, 1'b0, 32'h0},
		'{32'h0000_0000, 1'b0, 1'b0, 32'h0},
		'{32'hffff_ffff, 1'b1, 1'b0, 32'h0},
		// descending arrival
		'{32'h0000_0003, 1'b0, 1'b0, 32'h0},
		'{32'h0000_0002, 1'b0, 1'b0, 32'h0},
		'{32'h0000_0001, 1'b1, 1'b0, 32'h0},
		// ascending arrival
		'{32'hffff_fffe, 1'b0, 1'b0, 32'h0},
		'{32'hffff_ffff, 1'b1, 1'b0, 32'h0},
		// all equal
		'{32'h0000_0009, 1'b0, 1'b0, 32'h0},
		'{32'h0000_0009, 1'b0, 1'b0, 32'h0},
		'{32'h0000_0009, 1'b1, 1'b0, 32'h0}
	};

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	key_t key;
	logic last;
	logic out_valid;
	logic out_ready;
	key_t sorted_key;
	logic final_res;

	// side information for the word on offer: typed-in expectation
	logic cur_typed;
	key_t cur_exp;

	int snd_idle_pct;
	int rcv_stall_pct;
	int hold_reqs;
	int holds_done;

	key_t         held_keys [$];
	sorted_word_t due_words [$];

	int fails;
	int words_sent;
	int words_checked;
	int sets_closed;
	int keys_dropped;
	int quiet_cycles;

	regular_sampling_sorter_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.key        (key),
		.last       (last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sorted_key (sorted_key),
		.final_res  (final_res)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// insertion into the ascending copy, keys past the capacity are lost
	task file_key;
		int pos;
		int i;
		sorted_word_t w;
		if (held_keys.size() < SET_CAP) begin
			pos = held_keys.size();
			while (pos > 0 && held_keys[pos-1] > key)
				pos--;
			held_keys.insert(pos, key);
		end else begin
			keys_dropped++;
		end
		if (last) begin
			if (cur_typed) begin
				w.k   = cur_exp;
				w.fin = 1'b1;
				due_words.insert(due_words.size(), w);
			end else begin
				for (i = 0; i < held_keys.size(); i++) begin
					w.k   = held_keys[i];
					w.fin = (i == held_keys.size() - 1);
					due_words.insert(due_words.size(), w);
				end
			end
			held_keys.delete();
			sets_closed++;
		end
	endtask

	task check_sorted_word;
		sorted_word_t w;
		if (due_words.size() == 0) begin
			$error("unexpected word: sorted_key %0d final_res %0b", sorted_key, final_res);
			fails++;
		end else begin
			w = due_words.pop_front();
			if (sorted_key !== w.k) begin
				$error("sorted_key: expected %0d, got %0d", w.k, sorted_key);
				fails++;
			end
			if (final_res !== w.fin) begin
				$error("final_res: expected %0b, got %0b", w.fin, final_res);
				fails++;
			end
			words_checked++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			// output first: a word leaving now always belongs to an earlier set
			if (out_valid && out_ready)
				check_sorted_word();
			if (in_valid && in_ready)
				file_key();
			if ((out_valid && out_ready) || (in_valid && in_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout after %0d cycles without a handshake", quiet_cycles);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// receive side, with the long hold-off counted here
	initial begin
		int hold_left;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_reqs != holds_done) begin
				out_ready <= 1'b0;
				for (hold_left = HOLD_CYCLES; hold_left > 0; hold_left--)
					@(negedge clk);
				holds_done++;
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
			end
		end
	end

	task send_word(input key_t k, input logic l, input logic typed, input key_t k_exp);
		@(negedge clk);
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		key       <= k;
		last      <= l;
		cur_typed <= typed;
		cur_exp   <= k_exp;
		in_valid  <= 1'b1;
		do @(posedge clk); while (!in_ready);
		words_sent++;
	endtask

	function automatic key_t pick_key(key_mix_t mix);
		key_t k;
		case (mix)
			KEYS_CLUSTERED: k = key_t'(int'($urandom_range(0, 7)) - 4);
			KEYS_EXTREME: begin
				case ($urandom_range(0, 4))
					0: k = 32'h8000_0000;
					1: k = 32'h7fff_ffff;
					2: k = 32'hffff_ffff;
					3: k = 32'h0000_0001;
					default: k = '0;
				endcase
			end
			default: k = key_t'($urandom);
		endcase
		return k;
	endfunction

	task send_set(input int n, input key_mix_t mix);
		int i;
		for (i = 0; i < n; i++)
			send_word(pick_key(mix), i == n - 1, 1'b0, '0);
	endtask

	task drain;
		@(negedge clk);
		in_valid <= 1'b0;
		while (due_words.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	function automatic int pick_set_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 8);
		else if (r < 96)
			return $urandom_range(9, 40);
		return $urandom_range(60, 70);
	endfunction

	initial begin
		int i;
		int phase;
		int phase_start;
		int snd_pct [4];
		int rcv_pct [4];
		snd_pct = '{0, 47, 0, 15};
		rcv_pct = '{0, 0, 47, 15};
		in_valid      = 1'b0;
		key           = '0;
		last          = 1'b0;
		cur_typed     = 1'b0;
		cur_exp       = '0;
		snd_idle_pct  = 0;
		rcv_stall_pct = 0;
		hold_reqs     = 0;
		holds_done    = 0;
		fails         = 0;
		words_sent    = 0;
		words_checked = 0;
		sets_closed   = 0;
		keys_dropped  = 0;
		quiet_cycles  = 0;
		arst_n        = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		for (i = 0; i < N_DIR; i++)
			send_word(DIR_ROWS[i].k, DIR_ROWS[i].l, DIR_ROWS[i].typed, DIR_ROWS[i].k_exp);
		drain();

		// store full: the closing word is dropped but the held keys still go out
		send_set(SET_CAP + 1, KEYS_WIDE);
		drain();
		// overfull set, several keys dropped before the close
		send_set(SET_CAP + 4, KEYS_CLUSTERED);
		drain();

		// long receiver hold-off while words keep coming
		hold_reqs++;
		send_set(20, KEYS_WIDE);
		send_set(12, KEYS_CLUSTERED);
		send_set(5, KEYS_WIDE);
		drain();

		for (phase = 0; phase < 4; phase++) begin
			snd_idle_pct  = snd_pct[phase];
			rcv_stall_pct = rcv_pct[phase];
			phase_start   = words_sent;
			while (words_sent - phase_start < PHASE_WORDS)
				send_set(pick_set_size(), key_mix_t'($urandom_range(0, 2)));
			drain();
		end

		$display("%0d words sent in %0d sets, %0d sorted words checked, %0d keys dropped",
			words_sent, sets_closed, words_checked, keys_dropped);
		$display("covered extremes, duplicates, overfull sets, idle phases and a long hold-off");
		if (fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
`default_nettype wire

>>> sim.f
hdl/rss_pkg.sv
hdl/rss_cell.sv
hdl/regular_sampling_sorter_unit.sv
hdl/rss_checker.sv
sim/tb_regular_sampling_sorter_unit.sv
